[hw/rtl/sde_pkg.sv]
// Package for the sparse delta entry decoder: geometry constants, payload
// structs, register codes and reset values. No dependencies.
package sde_pkg;

   localparam int COL_BITS       = 5;
   localparam int CODEBOOK_DEPTH = 256;
   localparam int CB_ADDR_W      = (CODEBOOK_DEPTH > 1) ? $clog2(CODEBOOK_DEPTH) : 1;

   localparam logic [15:0] COL_MASK       = 16'((1 << COL_BITS) - 1);
   localparam logic [8:0]  CB_DEPTH_9     = 9'(CODEBOOK_DEPTH);
   localparam logic [15:0] ALPHA_RESET    = 16'd256;
   localparam logic [8:0]  TABLE_SZ_RESET = 9'd256;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   typedef enum logic [0:0] {
      REG_ALPHA      = 1'b0,
      REG_TABLE_SIZE = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic               func;
      logic               start_req;
      logic [7:0]         delta;
      logic [7:0]         index;
      logic signed [15:0] table_word;
   } req_type;

   typedef struct packed {
      logic [10:0]        row;
      logic [4:0]         col;
      logic signed [15:0] value;
   } rsp_type;

endpackage

[hw/rtl/sparse_delta_entry_decoder.sv]
// Sparse delta entry decoder top level: position accumulator, codebook memory,
// scale multiplier and output register. Depends on sde_pkg.
//
// Throughput: one item per cycle, set by the single codebook read port, unless
// rsp_stall backs the pipeline up and raises req_stall. Path: a decode item's codebook
// word is read into stage 1 at the accepting edge, multiplied into the stage 2 product
// register, then rounded/saturated into the output register that drives rsp_valid.
// Reset: pipeline valids and position clear, alpha = 1.0, table_size = 256.
// Codebook contents are not cleared; entries must be written before use.
module sparse_delta_entry_decoder (
   input  logic             clock,
   input  logic             reset,
   // entry items
   input  logic             req_valid,
   output logic             req_stall,
   input  sde_pkg::req_type req_data,
   // result items
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sde_pkg::rsp_type rsp_data,
   // APB register port
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // ---------------------------------------------------------------------
   // Registers: alpha at 0x0, table_size at 0x4
   // ---------------------------------------------------------------------
   logic [15:0]          alpha_ff;
   logic [8:0]           table_size_ff;
   logic                 csr_wr;
   sde_pkg::csr_reg_type csr_sel;

   assign pready  = 1'b1;
   assign csr_sel = sde_pkg::csr_reg_type'(paddr[2]);
   assign csr_wr  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff      <= sde_pkg::ALPHA_RESET;
         table_size_ff <= sde_pkg::TABLE_SZ_RESET;
      end else if (csr_wr) begin
         unique case (csr_sel)
            sde_pkg::REG_ALPHA:      alpha_ff      <= pwdata[15:0];
            sde_pkg::REG_TABLE_SIZE: table_size_ff <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         sde_pkg::REG_ALPHA:      prdata = {16'd0, alpha_ff};
         sde_pkg::REG_TABLE_SIZE: prdata = {23'd0, table_size_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline flow: each stage loads when it is empty or the next one is moving.
   // A result waiting in the output register does not block intake until
   // every stage behind it is full.
   // ---------------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, rsp_v_ff;
   logic en_out, en_s2, en_s1;
   logic req_take;

   assign en_out    = !rsp_v_ff || !rsp_stall;
   assign en_s2     = !s2_v_ff  || en_out;
   assign en_s1     = !s1_v_ff  || en_s2;
   assign req_stall = !en_s1;
   assign req_take  = req_valid && en_s1;

   // ---------------------------------------------------------------------
   // Stage 0: position update, drop check, codebook access
   // ---------------------------------------------------------------------
   logic [15:0] pos_ff, pos_in;
   logic        cb_in_range;
   logic        keep;
   logic        is_decode;

   assign is_decode   = (req_data.func == sde_pkg::FUNC_DECODE);
   assign cb_in_range = ({1'b0, req_data.index} < sde_pkg::CB_DEPTH_9);
   assign keep        = cb_in_range && ({1'b0, req_data.index} < table_size_ff);
   assign pos_in      = (req_data.start_req ? 16'd0 : pos_ff) + {8'd0, req_data.delta};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 16'd0;
      end else if (req_take && is_decode) begin
         pos_ff <= pos_in;
      end
   end

   // Codebook: written by write items, read by decode items. Each accepted
   // item touches it once, so a read always sees every earlier write.
   logic signed [15:0] cb_mem [sde_pkg::CODEBOOK_DEPTH];
   logic signed [15:0] rd_data_ff;
   logic [sde_pkg::CB_ADDR_W-1:0] cb_addr;

   assign cb_addr = req_data.index[sde_pkg::CB_ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (req_take && !is_decode && cb_in_range) begin
         cb_mem[cb_addr] <= req_data.table_word;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s1) begin
         rd_data_ff <= cb_mem[cb_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: codebook word ready, multiply by alpha
   // ---------------------------------------------------------------------
   logic [10:0] s1_row_ff, s1_col_tmp;
   logic [4:0]  s1_col_ff;

   assign s1_col_tmp = 11'(pos_in >> sde_pkg::COL_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en_s1) begin
         s1_v_ff <= req_take && is_decode && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s1) begin
         s1_row_ff <= s1_col_tmp;
         s1_col_ff <= 5'(pos_in & sde_pkg::COL_MASK);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: Q16.16 product registered
   // ---------------------------------------------------------------------
   logic signed [31:0] prod_in, s2_prod_ff;
   logic [10:0]        s2_row_ff;
   logic [4:0]         s2_col_ff;

   assign prod_in = rd_data_ff * $signed(alpha_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en_s2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s2) begin
         s2_prod_ff <= prod_in;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: round half up to Q8.8, saturate, output register
   // ---------------------------------------------------------------------
   logic signed [31:0] rnd_sum, rnd_shift;
   logic signed [15:0] sat_value;
   sde_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   assign rnd_sum   = s2_prod_ff + 32'sd128;  // |product| <= 2^30, no overflow
   assign rnd_shift = rnd_sum >>> 8;

   always_comb begin
      if (rnd_shift > 32'sd32767) begin
         sat_value = 16'sh7FFF;
      end else if (rnd_shift < -32'sd32768) begin
         sat_value = 16'sh8000;
      end else begin
         sat_value = rnd_shift[15:0];
      end
      rsp_data_in.row   = s2_row_ff;
      rsp_data_in.col   = s2_col_ff;
      rsp_data_in.value = sat_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en_out) begin
         rsp_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // intake only backs up when the whole pipe is full and the output waits
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_v_ff && s2_v_ff && s1_v_ff && rsp_stall))
      else $error("intake stalled with room in the pipeline");

   // a kept decode item enters stage 1
   a_keep_enters: assert property (@(posedge clock) disable iff (reset)
      (req_take && is_decode && keep) |=> s1_v_ff)
      else $error("kept entry lost at stage 1");

   // start flag restarts the position at the delta
   a_start_pos: assert property (@(posedge clock) disable iff (reset)
      (req_take && is_decode && req_data.start_req) |=>
         (pos_ff == {8'd0, $past(req_data.delta)}))
      else $error("position not restarted by start flag");

   // codebook writes leave the position alone
   a_write_pos: assert property (@(posedge clock) disable iff (reset)
      (req_take && !is_decode) |=> $stable(pos_ff))
      else $error("codebook write changed position");

   // a write item never creates stage 1 work
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_take && !is_decode) |=> !s1_v_ff)
      else $error("codebook write produced a result");

endmodule

[verif/sparse_delta_entry_decoder_test.sv]
// Self-checking testbench for sparse_delta_entry_decoder: codebook writes, decode
// items, scaling, drops and back-pressure, checked against a local predictor.
// Depends on sde_pkg and the decoder RTL only.
module sparse_delta_entry_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 300;   // receiver hold-off for the fill-up test
   localparam int STUCK_LIMIT     = 3000;  // cycles with no handshake before giving up
   localparam int SETTLE_CYCLES   = 8;     // settle time for dropped entries still in flight, with margin
   localparam int IDLE_PCT        = 6;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_valid  = 1'b0;
   logic             req_stall;
   sde_pkg::req_type req_data   = '0;
   logic             rsp_valid;
   logic             rsp_stall  = 1'b0;
   sde_pkg::rsp_type rsp_data;
   logic             psel       = 1'b0;
   logic             penable    = 1'b0;
   logic             pwrite     = 1'b0;
   logic [2:0]       paddr      = '0;
   logic [31:0]      pwdata     = '0;
   logic [31:0]      prdata;
   logic             pready;

   // Predictor state: mirrors the block's registers, position and codebook.
   logic signed [15:0] alpha_q88;
   logic [8:0]         table_size;
   logic [15:0]        position;
   logic signed [15:0] codebook [sde_pkg::CODEBOOK_DEPTH];
   bit                 written  [sde_pkg::CODEBOOK_DEPTH];

   sde_pkg::rsp_type pending_results [$];   // decoded entries not yet seen on rsp
   int               mismatches    = 0;

   // Stall control shared with the receiver process.
   bit calm          = 1'b0;       // no random idling on either side
   int hold_requests = 0;          // bumped by a test to ask for a long hold-off

   sparse_delta_entry_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Q8.8 x Q8.8 -> Q16.16, round half up to Q8.8, saturate to 16 bits.
   function automatic logic signed [15:0] scaled_value(logic signed [15:0] word,
                                                       logic signed [15:0] scale);
      longint prod;
      longint rounded;
      prod    = longint'(word) * longint'(scale);
      rounded = (prod + 128) >>> 8;   // arithmetic shift floors
      if (rounded > 32767)
         rounded = 32767;
      if (rounded < -32768)
         rounded = -32768;
      return 16'(rounded);
   endfunction

   // Called once per accepted entry item: updates state, queues any result.
   function automatic void decode_entry(sde_pkg::req_type it);
      sde_pkg::rsp_type res;
      if (it.func == sde_pkg::FUNC_WRITE) begin
         // start_req and delta play no part in a codebook write
         if (int'(it.index) < sde_pkg::CODEBOOK_DEPTH) begin
            codebook[it.index] = it.table_word;
            written[it.index]  = 1'b1;
         end
         return;
      end
      if (it.start_req)
         position = '0;
      position = position + 16'(it.delta);   // wraps at 16 bits
      // dropped entries still move the position but give nothing
      if (9'(it.index) >= table_size || int'(it.index) >= sde_pkg::CODEBOOK_DEPTH)
         return;
      res.row   = 11'(position >> sde_pkg::COL_BITS);
      res.col   = 5'(position & sde_pkg::COL_MASK);
      res.value = scaled_value(codebook[it.index], alpha_q88);
      pending_results.push_back(res);
   endfunction

   function automatic sde_pkg::req_type make_entry(logic f, logic st, logic [7:0] dl,
                                                   logic [7:0] ix, logic [15:0] wd);
      sde_pkg::req_type it;
      it.func       = f;
      it.start_req  = st;
      it.delta      = dl;
      it.index      = ix;
      it.table_word = wd;
      return it;
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one item and hold it until accepted. valid stays high afterwards
   // so back-to-back items follow without a gap; a gap or drain_results
   // lowers it in the step right after acceptance.
   task automatic send_entry(sde_pkg::req_type it);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      decode_entry(it);
   endtask

   // Stop offering items, wait for every expected result, then let any
   // dropped entry still in flight leave the pipeline.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write then read-back of one register. Only used while idle.
   task automatic write_register(sde_pkg::csr_reg_type which, logic [15:0] value);
      logic [31:0] readback;
      logic [15:0] keep_mask;
      keep_mask = (which == sde_pkg::REG_ALPHA) ? 16'hFFFF : 16'h01FF;

      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= 32'(value & keep_mask);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);

      if (which == sde_pkg::REG_ALPHA)
         alpha_q88 = value;
      else
         table_size = 9'(value);

      psel    <= 1'b1;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);

      if ((readback[15:0] & keep_mask) != (value & keep_mask)) begin
         $display("%0t: register %s read back: expected %h, actual %h",
                  $realtime, which.name(), value & keep_mask, readback[15:0] & keep_mask);
         mismatches++;
      end
   endtask

   // Random item: mostly decodes, some codebook writes. A decode that would
   // hit a codebook slot never written gets that slot written first.
   task automatic send_random_entry();
      logic [7:0]  ix;
      logic [7:0]  dl;
      logic [15:0] wd;
      int          pick;

      pick = $urandom_range(99);
      case ($urandom_range(5))
         0:       wd = 16'h7FFF;
         1:       wd = 16'h8000;
         2:       wd = 16'(signed'($urandom_range(512)) - 256);  // near +-1.0
         default: wd = 16'($urandom);
      endcase

      if (pick < 20) begin
         // codebook write, start_req and delta are noise here
         send_entry(make_entry(sde_pkg::FUNC_WRITE, 1'($urandom), 8'($urandom),
                               8'($urandom), wd));
         return;
      end

      case ($urandom_range(9))
         0:       dl = 8'd0;
         1:       dl = 8'd255;
         2, 3:    dl = 8'($urandom_range(3));
         default: dl = 8'($urandom);
      endcase
      if (table_size != 0 && $urandom_range(99) < 75)
         ix = 8'($urandom_range(int'(table_size) - 1));
      else
         ix = 8'($urandom);

      if (9'(ix) < table_size && !written[ix])
         send_entry(make_entry(sde_pkg::FUNC_WRITE, 1'b0, 8'd0, ix, wd));
      send_entry(make_entry(sde_pkg::FUNC_DECODE, ($urandom_range(99) < 10), dl, ix,
                            16'($urandom)));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset settings: alpha 1.0, full table. Extreme words, extreme deltas,
   // start flag on both item kinds.
   task automatic test_basic_decode();
      send_entry(make_entry(sde_pkg::FUNC_WRITE,  1'b0, 8'd0,   8'd0,   16'h7FFF));
      send_entry(make_entry(sde_pkg::FUNC_WRITE,  1'b0, 8'd0,   8'd255, 16'h8000));
      send_entry(make_entry(sde_pkg::FUNC_WRITE,  1'b0, 8'd0,   8'd1,   16'h0100));
      // start and delta on a write must not touch the position
      send_entry(make_entry(sde_pkg::FUNC_WRITE,  1'b1, 8'd255, 8'd2,   16'hFFFF));
      send_entry(make_entry(sde_pkg::FUNC_WRITE,  1'b0, 8'd0,   8'd3,   16'h0001));
      send_entry(make_entry(sde_pkg::FUNC_DECODE, 1'b1, 8'd0,   8'd0,   16'h0000));
      send_entry(make_entry(sde_pkg::FUNC_DECODE, 1'b0, 8'd255, 8'd255, 16'hFFFF));
      send_entry(make_entry(sde_pkg::FUNC_DECODE, 1'b0, 8'd255, 8'd1,   16'h0000));
      send_entry(make_entry(sde_pkg::FUNC_DECODE, 1'b1, 8'd37,  8'd2,   16'h0000));
      send_entry(make_entry(sde_pkg::FUNC_DECODE, 1'b0, 8'd0,   8'd3,   16'h0000));
      drain_results();
   endtask

   // Saturation both ways and round-half-up on +-0.5 LSB.
   task automatic test_scale_corners();
      logic [15:0] scales [3] = '{16'h7FFF, 16'h8000, 16'h0080};
      foreach (scales[k]) begin
         write_register(sde_pkg::REG_ALPHA, scales[k]);
         send_entry(make_entry(sde_pkg::FUNC_DECODE, 1'b0, 8'd1, 8'd0,   16'h0000));
         send_entry(make_entry(sde_pkg::FUNC_DECODE, 1'b0, 8'd1, 8'd255, 16'h0000));
         send_entry(make_entry(sde_pkg::FUNC_DECODE, 1'b0, 8'd1, 8'd2,   16'h0000));
         send_entry(make_entry(sde_pkg::FUNC_DECODE, 1'b0, 8'd1, 8'd3,   16'h0000));
         drain_results();
      end
   endtask

   // Index at the table size is dropped, but its delta still counts.
   task automatic test_dropped_entry();
      write_register(sde_pkg::REG_ALPHA, sde_pkg::ALPHA_RESET);
      write_register(sde_pkg::REG_TABLE_SIZE, 16'd2);
      send_entry(make_entry(sde_pkg::FUNC_DECODE, 1'b0, 8'd3, 8'd2, 16'h0000));
      send_entry(make_entry(sde_pkg::FUNC_DECODE, 1'b0, 8'd3, 8'd1, 16'h0000));
      drain_results();
   endtask

   // Random traffic under a series of settings, extremes included.
   task automatic test_random_mix();
      logic [15:0] scales [6];
      logic [15:0] sizes  [6];
      int          counts [6] = '{180, 180, 180, 60, 180, 180};
      scales = '{sde_pkg::ALPHA_RESET, 16'h8000, 16'h7FFF, 16'($urandom), 16'h0000,
                 16'($urandom)};
      sizes  = '{16'(sde_pkg::TABLE_SZ_RESET), 16'd255, 16'd1, 16'd0,
                 16'($urandom_range(1, 256)), 16'(sde_pkg::TABLE_SZ_RESET)};
      foreach (scales[k]) begin
         write_register(sde_pkg::REG_ALPHA, scales[k]);
         write_register(sde_pkg::REG_TABLE_SIZE, sizes[k]);
         repeat (counts[k]) send_random_entry();
         drain_results();
      end
   endtask

   // Receiver holds off for a long stretch while items keep coming: the
   // pipeline fills and req_stall has to rise.
   task automatic test_back_pressure();
      write_register(sde_pkg::REG_ALPHA, 16'($urandom));
      write_register(sde_pkg::REG_TABLE_SIZE, 16'd200);
      hold_requests <= hold_requests + 1;
      repeat (120) send_random_entry();
      drain_results();
   endtask

   // Long run with no idling on either side.
   task automatic test_steady_stream();
      write_register(sde_pkg::REG_ALPHA, sde_pkg::ALPHA_RESET);
      write_register(sde_pkg::REG_TABLE_SIZE, 16'(sde_pkg::TABLE_SZ_RESET));
      calm <= 1'b1;
      repeat (250) send_random_entry();
      drain_results();
      calm <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall, long hold-off on request
   // ------------------------------------------------------------------
   initial begin : receiver
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checker: oldest expectation against each accepted result
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      sde_pkg::rsp_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result row %0d col %0d value %h",
                     $realtime, rsp_data.row, rsp_data.col, rsp_data.value);
            mismatches++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_data.row !== exp_res.row) begin
               $display("%0t: row: expected %0d, actual %0d",
                        $realtime, exp_res.row, rsp_data.row);
               mismatches++;
            end
            if (rsp_data.col !== exp_res.col) begin
               $display("%0t: col: expected %0d, actual %0d",
                        $realtime, exp_res.col, rsp_data.col);
               mismatches++;
            end
            if (rsp_data.value !== exp_res.value) begin
               $display("%0t: value: expected %h, actual %h",
                        $realtime, exp_res.value, rsp_data.value);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: cycles in which no handshake of any kind completes
   // ------------------------------------------------------------------
   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            stuck = 0;
         else
            stuck++;
      end
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $realtime, STUCK_LIMIT, pending_results.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      alpha_q88  = sde_pkg::ALPHA_RESET;
      table_size = sde_pkg::TABLE_SZ_RESET;
      position   = '0;
      foreach (written[i]) begin
         written[i]  = 1'b0;
         codebook[i] = '0;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_decode();
      test_scale_corners();
      test_dropped_entry();
      test_random_mix();
      test_back_pressure();
      test_steady_stream();

      drain_results();
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[files.f]
hw/rtl/sde_pkg.sv
hw/rtl/sparse_delta_entry_decoder.sv
verif/sparse_delta_entry_decoder_test.sv
